### rtl/core/assert_macros.svh
// assertion macros for the port-level checker file
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on an explicit clock and active-low reset
`define ASSERT_CLKRST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same, on the block clock and reset
`define SRC_ASSERT(label, prop, msg) `ASSERT_CLKRST(label, clk_i, rst_ni, prop, msg)

`endif

### rtl/core/src_pkg.sv
// shared types, constants and helpers of the sensor reading compensation
// no dependencies
`default_nettype none

package src_pkg;

  localparam int unsigned DivSteps  = 64;
  localparam int unsigned FifoDepth = 4;

  localparam logic signed [32:0] TFineOffsetP = 33'sd128000;
  localparam logic [31:0] TFineOffsetH = 32'd76800;
  localparam logic [20:0] PressBase    = 21'd1048576;
  localparam logic [63:0] PressScale   = 64'd3125;
  localparam logic [63:0] PressBias    = 64'h0000_8000_0000_0000;
  localparam logic [31:0] HumClampMax  = 32'd419430400;
  localparam logic [31:0] HumRoundA    = 32'd16384;
  localparam logic [31:0] HumOffsetE   = 32'd2097152;
  localparam logic [31:0] HumRoundE    = 32'd8192;
  localparam logic [31:0] HumOffsetC   = 32'd32768;

  typedef struct packed {
    logic signed [15:0] t3;
    logic signed [15:0] t2;
    logic        [15:0] t1;
  } src_tcoef_t;

  typedef struct packed {
    logic signed [15:0] p9;
    logic signed [15:0] p8;
    logic signed [15:0] p7;
    logic signed [15:0] p6;
    logic signed [15:0] p5;
    logic signed [15:0] p4;
    logic signed [15:0] p3;
    logic signed [15:0] p2;
    logic        [15:0] p1;
  } src_pcoef_t;

  typedef struct packed {
    logic signed [7:0]  h6;
    logic signed [11:0] h5;
    logic signed [11:0] h4;
    logic        [7:0]  h3;
    logic signed [15:0] h2;
    logic        [7:0]  h1;
  } src_hcoef_t;

  // request as handed from front to back
  typedef struct packed {
    logic [31:0] tfine;
    logic [19:0] raw_p;
    logic [15:0] raw_h;
  } src_item_t;

  // results that ride alongside the divider
  typedef struct packed {
    logic        neg;
    logic        inv;
    logic [31:0] temp;
    logic [6:0]  hum;
  } src_side_t;

  function automatic logic [31:0] sra32(logic [31:0] v, int unsigned s);
    return 32'($signed(v) >>> s);
  endfunction

  function automatic logic [63:0] sra64(logic [63:0] v, int unsigned s);
    return 64'($signed(v) >>> s);
  endfunction

endpackage

`default_nettype wire

### rtl/core/src_front.sv
// front part: takes raw requests and works out the fine temperature
// depends on src_pkg
`default_nettype none

module src_front import src_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  src_tcoef_t  tcoef_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [19:0] raw_temperature_i,
  input  logic [19:0] raw_pressure_i,
  input  logic [15:0] raw_humidity_i,
  input  logic        full_i,
  output logic        push_o,
  output src_item_t   push_item_o
);

  logic [3:0] v_q;
  logic       en;

  logic [19:0] rt1_q, rp1_q, rp2_q, rp3_q, rp4_q;
  logic [15:0] rh1_q, rh2_q, rh3_q, rh4_q;
  logic [31:0] tv1p_q, tdsq_q, tv1_q, tv2p_q, tfine_q;

  logic signed [17:0] tdiff;
  logic signed [33:0] tv1_full;
  logic signed [16:0] td;
  logic signed [33:0] tdsq_full;
  logic signed [47:0] tv2_full;

  assign en         = !(v_q[3] && full_i);
  assign in_stall_o = !en;
  assign push_o     = v_q[3] && !full_i;

  assign tdiff     = $signed({1'b0, rt1_q[19:3]}) - $signed({1'b0, tcoef_i.t1, 1'b0});
  assign tv1_full  = tdiff * $signed(tcoef_i.t2);
  assign td        = $signed({1'b0, rt1_q[19:4]}) - $signed({1'b0, tcoef_i.t1});
  assign tdsq_full = td * td;
  assign tv2_full  = $signed(sra32(tdsq_q, 12)) * $signed(tcoef_i.t3);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rt1_q   <= raw_temperature_i;
      rp1_q   <= raw_pressure_i;
      rh1_q   <= raw_humidity_i;
      tv1p_q  <= tv1_full[31:0];
      tdsq_q  <= tdsq_full[31:0];
      rp2_q   <= rp1_q;
      rh2_q   <= rh1_q;
      tv1_q   <= sra32(tv1p_q, 11);
      tv2p_q  <= tv2_full[31:0];
      rp3_q   <= rp2_q;
      rh3_q   <= rh2_q;
      tfine_q <= tv1_q + sra32(tv2p_q, 14);
      rp4_q   <= rp3_q;
      rh4_q   <= rh3_q;
    end
  end

  assign push_item_o.tfine = tfine_q;
  assign push_item_o.raw_p = rp4_q;
  assign push_item_o.raw_h = rh4_q;

endmodule

`default_nettype wire

### rtl/core/src_fifo.sv
// short queue between front and back parts
// depends on src_pkg
`default_nettype none

module src_fifo import src_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  src_item_t item_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      empty_o,
  output src_item_t item_o
);

  localparam int unsigned PtrW = $clog2(FifoDepth);

  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;
  src_item_t       mem_q [FifoDepth];

  assign full_o  = (cnt_q == (PtrW+1)'(FifoDepth));
  assign empty_o = (cnt_q == '0);
  assign item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= item_i;
  end

endmodule

`default_nettype wire

### rtl/core/src_div.sv
// pipelined restoring divider, one quotient bit per stage
// depends on src_pkg
`default_nettype none

module src_div import src_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] n_i,
  input  logic [30:0] d_i,
  input  src_side_t   side_i,
  output logic [63:0] q_o,
  output src_side_t   side_o
);

  logic [30:0] r_q [DivSteps];
  logic [63:0] w_q [DivSteps];
  logic [30:0] d_q [DivSteps];
  src_side_t   s_q [DivSteps];
  logic [30:0] r_d [DivSteps];
  logic [63:0] w_d [DivSteps];

  // stage inputs: the first stage takes the ports, the rest the stage before
  logic [30:0] r_in [DivSteps];
  logic [63:0] w_in [DivSteps];
  logic [30:0] d_in [DivSteps];
  src_side_t   s_in [DivSteps];

  always_comb begin
    logic [31:0] trial;
    r_in[0] = '0;
    w_in[0] = n_i;
    d_in[0] = d_i;
    s_in[0] = side_i;
    for (int k = 1; k < DivSteps; k++) begin
      r_in[k] = r_q[k-1];
      w_in[k] = w_q[k-1];
      d_in[k] = d_q[k-1];
      s_in[k] = s_q[k-1];
    end
    for (int k = 0; k < DivSteps; k++) begin
      trial = {r_in[k], w_in[k][63]};
      if (trial >= {1'b0, d_in[k]}) begin
        r_d[k] = 31'(trial - {1'b0, d_in[k]});
        w_d[k] = {w_in[k][62:0], 1'b1};
      end else begin
        r_d[k] = trial[30:0];
        w_d[k] = {w_in[k][62:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < DivSteps; k++) begin
        r_q[k] <= r_d[k];
        w_q[k] <= w_d[k];
        d_q[k] <= d_in[k];
        s_q[k] <= s_in[k];
      end
    end
  end

  assign q_o    = w_q[DivSteps-1];
  assign side_o = s_q[DivSteps-1];

endmodule

`default_nettype wire

### rtl/core/src_back.sv
// back part: temperature scaling, pressure and humidity compensation, output register
// depends on src_pkg and src_div
`default_nettype none

module src_back import src_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  src_pcoef_t  pcoef_i,
  input  src_hcoef_t  hcoef_i,
  input  src_item_t   item_i,
  input  logic        empty_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] temperature_centi_o,
  output logic [31:0] pressure_q24_8_o,
  output logic        pressure_invalid_o,
  output logic [6:0]  humidity_percent_o
);

  localparam int unsigned PreStages  = 9;
  localparam int unsigned PostStages = 6;
  localparam int unsigned NumStages  = PreStages + DivSteps + PostStages;

  logic [NumStages-1:0] v_q;
  logic en;

  // stage 1
  logic signed [32:0] s1_v1_q;
  logic [31:0] s1_hv_q, s1_temp_q, t5;
  logic [19:0] s1_rp_q;
  logic [15:0] s1_rh_q;
  // stage 2
  logic signed [65:0] sq_full;
  logic signed [48:0] v1p5_full, v1p2_full, s2_v1p5_q, s2_v1p2_q;
  logic signed [43:0] h5hv_full;
  logic signed [39:0] hvh6_full;
  logic signed [40:0] hvh3_full;
  logic [63:0] s2_sq_q;
  logic [31:0] s2_h5hv_q, s2_hvh6_q, s2_hvh3_q, s2_temp_q;
  logic [19:0] s2_rp_q;
  logic [15:0] s2_rh_q;
  // stage 3
  logic signed [79:0] sqp6_full, sqp3_full;
  logic signed [48:0] s3_v1p5_q, s3_v1p2_q;
  logic [63:0] s3_sqp6_q, s3_sqp3_q;
  logic [31:0] ha_pre, s3_ha_q, s3_hb_q, s3_hc_q, s3_temp_q;
  logic [19:0] s3_rp_q;
  // stage 4
  logic signed [63:0] hbhc_full;
  logic [63:0] v1p5_x, v1p2_x, v2_sum, v1b, s4_v2_q, s4_x_q;
  logic [31:0] s4_hm_q, s4_ha_q, s4_temp_q;
  logic [19:0] s4_rp_q;
  // stage 5
  logic signed [80:0] prod_full;
  logic signed [47:0] hmh2_full;
  logic [20:0] pdiff;
  logic [63:0] s5_prod_q, s5_pp_q;
  logic [31:0] s5_he_q, s5_ha_q, s5_temp_q;
  // stage 6
  logic signed [63:0] hahe_full;
  logic [63:0] n_scaled, s6_n_q;
  logic [30:0] s6_d_q;
  logic [31:0] s6_hv2_q, s6_temp_q;
  // stage 7
  logic signed [63:0] hshs_full;
  logic [31:0] hs, s7_hsq_q, s7_hv2_q, s7_temp_q;
  logic [63:0] s7_n_q;
  logic [30:0] s7_d_q;
  logic s7_neg_q, s7_inv_q;
  // stage 8
  logic signed [40:0] hx_full;
  logic [31:0] s8_hxp_q, s8_hv2_q, s8_temp_q;
  logic [63:0] s8_n_q;
  logic [30:0] s8_d_q;
  logic s8_neg_q, s8_inv_q;
  // stage 9
  logic [31:0] hf, hf_cl;
  logic [63:0] s9_n_q;
  logic [30:0] s9_d_q;
  src_side_t   s9_side_q;
  // divider and after
  logic [63:0] dq;
  src_side_t   dside;
  logic [63:0] p1_p_q;
  src_side_t   p1_side_q;
  logic [63:0] q13, p2_ll_q, p2_p_q, sq_ll;
  logic [31:0] sq_x, p2_x_q;
  logic signed [79:0] p8p_full;
  logic [63:0] p2_p8p_q;
  src_side_t   p2_side_q;
  logic [63:0] p3_qq_q, p3_v2_q, p3_p_q;
  src_side_t   p3_side_q;
  logic signed [79:0] t_full;
  logic [63:0] p4_t_q, p4_v2_q, p4_p_q;
  src_side_t   p4_side_q;
  logic [63:0] p5_s_q;
  src_side_t   p5_side_q;
  logic [63:0] f_fin;
  logic [31:0] pres;
  logic [31:0] out_temp_q, out_pres_q;
  logic        out_inv_q;
  logic [6:0]  out_hum_q;

  assign en    = !(v_q[NumStages-1] && out_stall_i);
  assign pop_o = en && !empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NumStages-2:0], pop_o};
    end
  end

  assign t5        = {item_i.tfine[29:0], 2'b00} + item_i.tfine + 32'd128;
  assign sq_full   = s1_v1_q * s1_v1_q;
  assign v1p5_full = s1_v1_q * $signed(pcoef_i.p5);
  assign v1p2_full = s1_v1_q * $signed(pcoef_i.p2);
  assign h5hv_full = $signed(s1_hv_q) * $signed(hcoef_i.h5);
  assign hvh6_full = $signed(s1_hv_q) * $signed(hcoef_i.h6);
  assign hvh3_full = $signed(s1_hv_q) * $signed({1'b0, hcoef_i.h3});
  assign sqp6_full = $signed(s2_sq_q) * $signed(pcoef_i.p6);
  assign sqp3_full = $signed(s2_sq_q) * $signed(pcoef_i.p3);
  assign ha_pre    = {2'b00, s2_rh_q, 14'd0} - {hcoef_i.h4, 20'd0} - s2_h5hv_q + HumRoundA;
  assign v1p5_x    = {{15{s3_v1p5_q[48]}}, s3_v1p5_q};
  assign v1p2_x    = {{15{s3_v1p2_q[48]}}, s3_v1p2_q};
  assign v2_sum    = s3_sqp6_q + (v1p5_x << 17) + ({{48{pcoef_i.p4[15]}}, pcoef_i.p4} << 35);
  assign v1b       = sra64(s3_sqp3_q, 8) + (v1p2_x << 12);
  assign hbhc_full = $signed(s3_hb_q) * $signed(s3_hc_q);
  assign prod_full = $signed(s4_x_q) * $signed({1'b0, pcoef_i.p1});
  assign pdiff     = PressBase - {1'b0, s4_rp_q};
  assign hmh2_full = $signed(s4_hm_q) * $signed(hcoef_i.h2);
  assign n_scaled  = s5_pp_q * PressScale;
  assign hahe_full = $signed(s5_ha_q) * $signed(s5_he_q);
  assign hs        = sra32(s6_hv2_q, 15);
  assign hshs_full = $signed(hs) * $signed(hs);
  assign hx_full   = $signed(sra32(s7_hsq_q, 7)) * $signed({1'b0, hcoef_i.h1});
  assign hf        = s8_hv2_q - sra32(s8_hxp_q, 4);

  // humidity clamp to 0 .. 100 percent in Q10.22
  always_comb begin
    if (hf[31])                 hf_cl = '0;
    else if (hf > HumClampMax)  hf_cl = HumClampMax;
    else                        hf_cl = hf;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_v1_q   <= $signed({item_i.tfine[31], item_i.tfine}) - TFineOffsetP;
      s1_hv_q   <= item_i.tfine - TFineOffsetH;
      s1_temp_q <= sra32(t5, 8);
      s1_rp_q   <= item_i.raw_p;
      s1_rh_q   <= item_i.raw_h;

      s2_sq_q   <= sq_full[63:0];
      s2_v1p5_q <= v1p5_full;
      s2_v1p2_q <= v1p2_full;
      s2_h5hv_q <= h5hv_full[31:0];
      s2_hvh6_q <= hvh6_full[31:0];
      s2_hvh3_q <= hvh3_full[31:0];
      s2_temp_q <= s1_temp_q;
      s2_rp_q   <= s1_rp_q;
      s2_rh_q   <= s1_rh_q;

      s3_sqp6_q <= sqp6_full[63:0];
      s3_sqp3_q <= sqp3_full[63:0];
      s3_v1p5_q <= s2_v1p5_q;
      s3_v1p2_q <= s2_v1p2_q;
      s3_ha_q   <= sra32(ha_pre, 15);
      s3_hb_q   <= sra32(s2_hvh6_q, 10);
      s3_hc_q   <= sra32(s2_hvh3_q, 11) + HumOffsetC;
      s3_temp_q <= s2_temp_q;
      s3_rp_q   <= s2_rp_q;

      s4_v2_q   <= v2_sum;
      s4_x_q    <= PressBias + v1b;
      s4_hm_q   <= sra32(hbhc_full[31:0], 10) + HumOffsetE;
      s4_ha_q   <= s3_ha_q;
      s4_temp_q <= s3_temp_q;
      s4_rp_q   <= s3_rp_q;

      s5_prod_q <= prod_full[63:0];
      s5_pp_q   <= ({43'd0, pdiff} << 31) - s4_v2_q;
      s5_he_q   <= sra32(hmh2_full[31:0] + HumRoundE, 14);
      s5_ha_q   <= s4_ha_q;
      s5_temp_q <= s4_temp_q;

      s6_d_q    <= s5_prod_q[63:33];
      s6_n_q    <= n_scaled;
      s6_hv2_q  <= hahe_full[31:0];
      s6_temp_q <= s5_temp_q;

      s7_neg_q  <= s6_n_q[63] ^ s6_d_q[30];
      s7_inv_q  <= (s6_d_q == '0);
      s7_n_q    <= s6_n_q[63] ? (~s6_n_q + 64'd1) : s6_n_q;
      s7_d_q    <= s6_d_q[30] ? (~s6_d_q + 31'd1) : s6_d_q;
      s7_hsq_q  <= hshs_full[31:0];
      s7_hv2_q  <= s6_hv2_q;
      s7_temp_q <= s6_temp_q;

      s8_hxp_q  <= hx_full[31:0];
      s8_hv2_q  <= s7_hv2_q;
      s8_temp_q <= s7_temp_q;
      s8_n_q    <= s7_n_q;
      s8_d_q    <= s7_d_q;
      s8_neg_q  <= s7_neg_q;
      s8_inv_q  <= s7_inv_q;

      s9_n_q         <= s8_n_q;
      s9_d_q         <= s8_d_q;
      s9_side_q.neg  <= s8_neg_q;
      s9_side_q.inv  <= s8_inv_q;
      s9_side_q.temp <= s8_temp_q;
      s9_side_q.hum  <= hf_cl[28:22];
    end
  end

  src_div u_div (
    .clk_i  (clk_i),
    .en_i   (en),
    .n_i    (s9_n_q),
    .d_i    (s9_d_q),
    .side_i (s9_side_q),
    .q_o    (dq),
    .side_o (dside)
  );

  assign q13      = sra64(p1_p_q, 13);
  assign sq_ll    = q13[31:0] * q13[31:0];
  assign sq_x     = q13[31:0] * q13[63:32];
  assign p8p_full = $signed(p1_p_q) * $signed(pcoef_i.p8);
  assign t_full   = $signed(p3_qq_q) * $signed(pcoef_i.p9);
  assign f_fin    = sra64(p5_s_q, 8) + ({{48{pcoef_i.p7[15]}}, pcoef_i.p7} << 4);

  // saturate to 32 bits unsigned, zero when the divisor was zero or the result negative
  always_comb begin
    if (p5_side_q.inv || f_fin[63]) pres = '0;
    else if (|f_fin[62:32])         pres = '1;
    else                            pres = f_fin[31:0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_p_q    <= dside.neg ? (~dq + 64'd1) : dq;
      p1_side_q <= dside;

      p2_ll_q   <= sq_ll;
      p2_x_q    <= sq_x;
      p2_p8p_q  <= p8p_full[63:0];
      p2_p_q    <= p1_p_q;
      p2_side_q <= p1_side_q;

      p3_qq_q   <= p2_ll_q + {p2_x_q[30:0], 33'd0};
      p3_v2_q   <= sra64(p2_p8p_q, 19);
      p3_p_q    <= p2_p_q;
      p3_side_q <= p2_side_q;

      p4_t_q    <= t_full[63:0];
      p4_v2_q   <= p3_v2_q;
      p4_p_q    <= p3_p_q;
      p4_side_q <= p3_side_q;

      p5_s_q    <= p4_p_q + sra64(p4_t_q, 25) + p4_v2_q;
      p5_side_q <= p4_side_q;

      out_temp_q <= p5_side_q.temp;
      out_pres_q <= pres;
      out_inv_q  <= p5_side_q.inv;
      out_hum_q  <= p5_side_q.hum;
    end
  end

  assign out_valid_o         = v_q[NumStages-1];
  assign temperature_centi_o = out_temp_q;
  assign pressure_q24_8_o    = out_pres_q;
  assign pressure_invalid_o  = out_inv_q;
  assign humidity_percent_o  = out_hum_q;

endmodule

`default_nettype wire

### rtl/core/sensor_reading_compensation.sv
// top level: calibration registers, front part, queue and back part
// depends on src_pkg, src_front, src_fifo, src_back
//
//  channel   direction  handshake             payload
//  request   in         in_valid_i/in_stall_o  raw temperature, pressure, humidity
//  result    out        out_valid_o/out_stall_i temperature, pressure, invalid, humidity
//  config    in         apb psel/penable       five calibration registers, 8-byte stride
//
// one request a cycle while the result channel is not stalled; the delay from the accepting
// edge to out_valid_o is set mostly by the 64-stage restoring divider of the pressure path
// reset clears valid bits, queue pointers and calibration registers
// a stalled result holds the whole back pipeline; the queue then fills and the
// front stalls its input once its last stage cannot hand over
`default_nettype none

module sensor_reading_compensation import src_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [19:0] raw_temperature_i,
  input  logic [19:0] raw_pressure_i,
  input  logic [15:0] raw_humidity_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] temperature_centi_o,
  output logic [31:0] pressure_q24_8_o,
  output logic        pressure_invalid_o,
  output logic [6:0]  humidity_percent_o,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  // register map, one 64-bit slot each
  typedef enum logic [2:0] {
    RegTemp      = 3'd0,
    RegPressA    = 3'd1,
    RegPressB    = 3'd2,
    RegPressNine = 3'd3,
    RegHum       = 3'd4
  } reg_idx_e;

  logic [47:0] temp_q;
  logic [63:0] pa_q, pb_q, hum_q;
  logic [15:0] p9_q;
  logic        wr_en;
  reg_idx_e    idx;

  src_tcoef_t tcoef;
  src_pcoef_t pcoef;
  src_hcoef_t hcoef;

  logic      full, empty, push, pop;
  src_item_t push_item, pop_item;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[5:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_q <= '0;
      pa_q   <= '0;
      pb_q   <= '0;
      p9_q   <= '0;
      hum_q  <= '0;
    end else if (wr_en) begin
      case (idx)
        RegTemp:      temp_q <= pwdata[47:0];
        RegPressA:    pa_q   <= pwdata;
        RegPressB:    pb_q   <= pwdata;
        RegPressNine: p9_q   <= pwdata[15:0];
        RegHum:       hum_q  <= pwdata;
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (idx)
      RegTemp:      prdata = {16'd0, temp_q};
      RegPressA:    prdata = pa_q;
      RegPressB:    prdata = pb_q;
      RegPressNine: prdata = {48'd0, p9_q};
      RegHum:       prdata = hum_q;
      default:      prdata = '0;
    endcase
  end

  // coefficient fields straight from the packed registers
  assign tcoef = src_tcoef_t'(temp_q);
  assign pcoef = src_pcoef_t'({p9_q, pb_q, pa_q});
  assign hcoef = src_hcoef_t'(hum_q);

  src_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .tcoef_i           (tcoef),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .raw_temperature_i (raw_temperature_i),
    .raw_pressure_i    (raw_pressure_i),
    .raw_humidity_i    (raw_humidity_i),
    .full_i            (full),
    .push_o            (push),
    .push_item_o       (push_item)
  );

  src_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .item_o  (pop_item)
  );

  src_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .pcoef_i             (pcoef),
    .hcoef_i             (hcoef),
    .item_i              (pop_item),
    .empty_i             (empty),
    .pop_o               (pop),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .temperature_centi_o (temperature_centi_o),
    .pressure_q24_8_o    (pressure_q24_8_o),
    .pressure_invalid_o  (pressure_invalid_o),
    .humidity_percent_o  (humidity_percent_o)
  );

endmodule

`default_nettype wire

### rtl/core/src_checker.sv
// port-level checker for the compensation block, bound to the top level
// depends on assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module src_port_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] temperature_centi_o,
  input logic [31:0] pressure_q24_8_o,
  input logic        pressure_invalid_o,
  input logic [6:0]  humidity_percent_o
);

  `SRC_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o, "result dropped while stalled")
  `SRC_ASSERT(a_out_stable, out_valid_o && out_stall_i |=> $stable(pressure_q24_8_o) && $stable(temperature_centi_o), "stalled result changed")
  `SRC_ASSERT(a_inv_zero, out_valid_o && pressure_invalid_o |-> pressure_q24_8_o == 32'd0, "invalid pressure not zero")
  `SRC_ASSERT(a_hum_range, out_valid_o |-> humidity_percent_o <= 7'd100, "humidity above clamp")

endmodule

bind sensor_reading_compensation src_port_checker u_src_checker (.*);

`default_nettype wire

### tb/src_checker.sv
// checker for the sensor reading compensation: snoops the request, result and apb ports,
// predicts every result from its own copy of the calibration and compares field by field
// depends on nothing outside this file
`default_nettype none

module src_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [19:0] raw_temperature_i,
  input  logic [19:0] raw_pressure_i,
  input  logic [15:0] raw_humidity_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [31:0] temperature_centi_i,
  input  logic [31:0] pressure_q24_8_i,
  input  logic        pressure_invalid_i,
  input  logic [6:0]  humidity_percent_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [5:0]  paddr_i,
  input  logic [63:0] pwdata_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          invalid_seen_o,
  output int          saturated_seen_o
);

  localparam logic [2:0] RegTemp  = 3'd0;
  localparam logic [2:0] RegPresA = 3'd1;
  localparam logic [2:0] RegPresB = 3'd2;
  localparam logic [2:0] RegPres9 = 3'd3;
  localparam logic [2:0] RegHum   = 3'd4;

  typedef struct packed {
    logic [31:0] temp;
    logic [31:0] press;
    logic        inv;
    logic [6:0]  hum;
  } reading_t;

  logic [63:0] cal_temp, cal_pres_a, cal_pres_b, cal_pres_9, cal_hum;
  reading_t    compensated_q[$];

  function automatic logic [31:0] sar32(input logic [31:0] v, input int unsigned s);
    logic signed [31:0] sv;
    sv = v;
    return sv >>> s;
  endfunction

  function automatic logic [63:0] sar64(input logic [63:0] v, input int unsigned s);
    logic signed [63:0] sv;
    sv = v;
    return sv >>> s;
  endfunction

  // sign-extended bit field as a 64-bit pattern
  function automatic logic [63:0] sfld(input logic [63:0] v, input int unsigned pos,
                                       input int unsigned w);
    logic [63:0] m, f;
    m = 64'd1 << (w - 1);
    f = (v >> pos) & ((m << 1) - 64'd1);
    return (f ^ m) - m;
  endfunction

  function automatic logic [63:0] ufld(input logic [63:0] v, input int unsigned pos,
                                       input int unsigned w);
    return (v >> pos) & ((64'd1 << w) - 64'd1);
  endfunction

  // signed division truncating towards zero, done on magnitudes
  function automatic logic [63:0] div_trunc(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] mn, md, q;
    mn = n[63] ? -n : n;
    md = d[63] ? -d : d;
    q  = mn / md;
    return (n[63] != d[63]) ? -q : q;
  endfunction

  function automatic reading_t compensate(input logic [19:0] rt, input logic [19:0] rp,
                                          input logic [15:0] rh);
    reading_t r;
    logic [31:0] adc_t, t1, t2, t3, a, b, td, tv1, tv2, tfine;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, v1, v2, p, q, n;
    logic [31:0] adc_h, h1, h2, h3, h4, h5, h6, hv, ha, hb, hc, he, hs, x;
    // temperature
    adc_t = {12'd0, rt};
    t1 = 32'(ufld(cal_temp, 0, 16));
    t2 = 32'(sfld(cal_temp, 16, 16));
    t3 = 32'(sfld(cal_temp, 32, 16));
    a = (adc_t >> 3) - (t1 << 1);
    tv1 = sar32(a * t2, 11);
    td = (adc_t >> 4) - t1;
    b = sar32(td * td, 12);
    tv2 = sar32(b * t3, 14);
    tfine = tv1 + tv2;
    r.temp = sar32(tfine * 32'd5 + 32'd128, 8);
    // pressure, 64-bit wrap
    p1 = ufld(cal_pres_a, 0, 16);
    p2 = sfld(cal_pres_a, 16, 16);
    p3 = sfld(cal_pres_a, 32, 16);
    p4 = sfld(cal_pres_a, 48, 16);
    p5 = sfld(cal_pres_b, 0, 16);
    p6 = sfld(cal_pres_b, 16, 16);
    p7 = sfld(cal_pres_b, 32, 16);
    p8 = sfld(cal_pres_b, 48, 16);
    p9 = sfld(cal_pres_9, 0, 16);
    v1 = sfld({32'd0, tfine}, 0, 32) - 64'd128000;
    v2 = v1 * v1 * p6;
    v2 = v2 + ((v1 * p5) << 17);
    v2 = v2 + (p4 << 35);
    v1 = sar64(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
    v1 = sar64(((64'd1 << 47) + v1) * p1, 33);
    r.press = 32'd0;
    r.inv = 1'b0;
    if (v1 == 64'd0) begin
      r.inv = 1'b1;
    end else begin
      p = 64'd1048576 - {44'd0, rp};
      n = ((p << 31) - v2) * 64'd3125;
      p = div_trunc(n, v1);
      q = sar64(p, 13);
      v1 = sar64(p9 * q * q, 25);
      v2 = sar64(p8 * p, 19);
      p = sar64(p + v1 + v2, 8) + (p7 << 4);
      if (p[63]) r.press = 32'd0;
      else if (p > 64'hFFFF_FFFF) r.press = 32'hFFFF_FFFF;
      else r.press = p[31:0];
    end
    // humidity
    adc_h = {16'd0, rh};
    h1 = 32'(ufld(cal_hum, 0, 8));
    h2 = 32'(sfld(cal_hum, 8, 16));
    h3 = 32'(ufld(cal_hum, 24, 8));
    h4 = 32'(sfld(cal_hum, 32, 12));
    h5 = 32'(sfld(cal_hum, 44, 12));
    h6 = 32'(sfld(cal_hum, 56, 8));
    hv = tfine - 32'd76800;
    ha = sar32((adc_h << 14) - (h4 << 20) - (h5 * hv) + 32'd16384, 15);
    hb = sar32(hv * h6, 10);
    hc = sar32(hv * h3, 11) + 32'd32768;
    x  = sar32(hb * hc, 10) + 32'd2097152;
    he = sar32(x * h2 + 32'd8192, 14);
    x  = ha * he;
    hs = sar32(x, 15);
    x  = x - sar32(sar32(hs * hs, 7) * h1, 4);
    if (x[31]) x = 32'd0;
    else if (x > 32'd419430400) x = 32'd419430400;
    r.hum = x[28:22];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    reading_t exp_r;
    if (!rst_ni) begin
      cal_temp <= '0;
      cal_pres_a <= '0;
      cal_pres_b <= '0;
      cal_pres_9 <= '0;
      cal_hum <= '0;
      fail_count_o <= 0;
      invalid_seen_o <= 0;
      saturated_seen_o <= 0;
      compensated_q.delete();
    end else begin
      if (psel_i && penable_i && pwrite_i) begin
        case (paddr_i[5:3])
          RegTemp:  cal_temp   <= pwdata_i & 64'h0000_FFFF_FFFF_FFFF;
          RegPresA: cal_pres_a <= pwdata_i;
          RegPresB: cal_pres_b <= pwdata_i;
          RegPres9: cal_pres_9 <= pwdata_i & 64'hFFFF;
          RegHum:   cal_hum    <= pwdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i)
        compensated_q.push_back(compensate(raw_temperature_i, raw_pressure_i,
                                           raw_humidity_i));
      if (out_valid_i && !out_stall_i) begin
        if (pressure_invalid_i) invalid_seen_o <= invalid_seen_o + 1;
        if (pressure_q24_8_i == 32'hFFFF_FFFF) saturated_seen_o <= saturated_seen_o + 1;
        if (compensated_q.size() == 0) begin
          if (fail_count_o < 10) $display("unexpected result with nothing outstanding");
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_r = compensated_q.pop_front();
          if (exp_r.temp !== temperature_centi_i || exp_r.press !== pressure_q24_8_i ||
              exp_r.inv !== pressure_invalid_i || exp_r.hum !== humidity_percent_i) begin
            if (fail_count_o < 10)
              $display("mismatch: exp t=%0d p=%0d inv=%0b h=%0d  got t=%0d p=%0d inv=%0b h=%0d",
                       $signed(exp_r.temp), exp_r.press, exp_r.inv, exp_r.hum,
                       $signed(temperature_centi_i), pressure_q24_8_i,
                       pressure_invalid_i, humidity_percent_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

  assign pending_o = compensated_q.size();

endmodule

`default_nettype wire

### tb/sensor_reading_compensation_tb.sv
// top of the sensor reading compensation testbench: clock, reset, apb writes and stimulus
// depends on src_pkg, sensor_reading_compensation and src_checker
`default_nettype none

module sensor_reading_compensation_tb;
  import src_pkg::*;

  localparam logic [5:0] AddrTemp  = 6'd0;
  localparam logic [5:0] AddrPresA = 6'd8;
  localparam logic [5:0] AddrPresB = 6'd16;
  localparam logic [5:0] AddrPres9 = 6'd24;
  localparam logic [5:0] AddrHum   = 6'd32;
  localparam int         RandomPhases = 8;
  localparam int         PerPhase     = 154;

  logic        clk_i, rst_ni;
  logic        in_valid_i, in_stall_o;
  logic [19:0] raw_temperature_i, raw_pressure_i;
  logic [15:0] raw_humidity_i;
  logic        out_valid_o, out_stall_i;
  logic [31:0] temperature_centi_o, pressure_q24_8_o;
  logic        pressure_invalid_o;
  logic [6:0]  humidity_percent_o;
  logic        psel, penable, pwrite, pready;
  logic [5:0]  paddr;
  logic [63:0] pwdata, prdata;

  int fail_count, pending, invalid_seen, saturated_seen;
  int idle_pct, stall_pct, requests_sent, settings_used;

  sensor_reading_compensation dut (.*);

  src_checker checker_i (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_i(in_stall_o),
    .raw_temperature_i, .raw_pressure_i, .raw_humidity_i,
    .out_valid_i(out_valid_o), .out_stall_i,
    .temperature_centi_i(temperature_centi_o), .pressure_q24_8_i(pressure_q24_8_o),
    .pressure_invalid_i(pressure_invalid_o), .humidity_percent_i(humidity_percent_o),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata),
    .fail_count_o(fail_count), .pending_o(pending),
    .invalid_seen_o(invalid_seen), .saturated_seen_o(saturated_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // hard stop well beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk_i) begin
    out_stall_i <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
  end

  // apb write: setup cycle, then access cycle; pready is always high
  task automatic cal_write(input logic [5:0] addr, input logic [63:0] data);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic load_calibration(input logic [63:0] t, input logic [63:0] pa,
                                  input logic [63:0] pb, input logic [63:0] p9,
                                  input logic [63:0] h);
    cal_write(AddrTemp, t);
    cal_write(AddrPresA, pa);
    cal_write(AddrPresB, pb);
    cal_write(AddrPres9, p9);
    cal_write(AddrHum, h);
    settings_used++;
  endtask

  // let every outstanding result drain, plus some slack for the pipeline
  task automatic drain;
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  // one request; the sender may first sit idle; valid stays high across back-to-back requests
  task automatic send_request(input logic [19:0] t, input logic [19:0] p, input logic [15:0] h);
    int gap;
    gap = 0;
    while (idle_pct > 0 && $urandom_range(99) < idle_pct && gap < 40) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    raw_temperature_i <= t;
    raw_pressure_i <= p;
    raw_humidity_i <= h;
    // stall is stable mid-cycle, so look at it on the falling edge
    forever begin
      @(negedge clk_i);
      if (!in_stall_o) break;
    end
    @(posedge clk_i);
    requests_sent++;
  endtask

  // mostly plausible readings, with a share drawn from the full field ranges
  task automatic send_random_request;
    if ($urandom_range(9) < 7)
      send_request(20'($urandom_range(600000, 400000)), 20'($urandom_range(500000, 250000)),
                   16'($urandom_range(40000, 20000)));
    else
      send_request(20'($urandom), 20'($urandom), 16'($urandom));
  endtask

  // typical factory calibration words
  localparam logic [15:0] T1 = 16'd27504, T2 = 16'd26435, T3 = -16'sd1000;
  localparam logic [63:0] TypTemp  = {16'd0, T3, T2, T1};
  localparam logic [63:0] TypPresA = {16'd2855, 16'd3024, -16'sd10685, 16'd36477};
  localparam logic [63:0] TypPresB = {-16'sd14600, 16'd15500, -16'sd7, 16'd140};
  localparam logic [63:0] TypPres9 = 64'd6000;
  localparam logic [63:0] TypHum   = {8'd30, 12'd50, 12'd313, 8'd0, 16'd362, 8'd75};

  initial begin
    int k;
    logic [63:0] jitter;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    raw_temperature_i = '0;
    raw_pressure_i = '0;
    raw_humidity_i = '0;
    out_stall_i = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    idle_pct = 0;
    stall_pct = 0;
    requests_sent = 0;
    settings_used = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset calibration is all zero: zero divisor, so pressure must read invalid
    send_request(20'd0, 20'd0, 16'd0);
    send_request(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    send_request(20'd519888, 20'd415148, 16'd30000);
    drain();

    // typical calibration: field extremes, clamps at both ends of humidity
    load_calibration(TypTemp, TypPresA, TypPresB, TypPres9, TypHum);
    send_request(20'd519888, 20'd415148, 16'd30000);
    send_request(20'd0, 20'd0, 16'd0);
    send_request(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    send_request(20'd0, 20'hFFFFF, 16'hFFFF);
    send_request(20'hFFFFF, 20'd0, 16'd0);
    send_request(20'd519888, 20'd0, 16'hFFFF);
    send_request(20'd519888, 20'hFFFFF, 16'd0);
    send_request(20'h80000, 20'h80000, 16'h8000);
    send_request(20'h7FFFF, 20'h7FFFF, 16'h7FFF);
    drain();

    // zero calibration except P1: exercises the plain divide path
    load_calibration(64'd0, 64'd1, 64'd0, 64'd0, 64'd0);
    send_request(20'd0, 20'd0, 16'd0);
    send_request(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    drain();

    // all ones, then most negative coefficients: wrap-around everywhere
    load_calibration('1, '1, '1, '1, '1);
    send_request(20'd0, 20'd0, 16'd0);
    send_request(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    send_request(20'd519888, 20'd415148, 16'd30000);
    drain();
    load_calibration(64'h8000_8000_FFFF, {4{16'h8000}} | 64'hFFFF, {4{16'h8000}},
                     64'h8000, 64'h8080_0800_FF80_00FF);
    send_request(20'd0, 20'd0, 16'd0);
    send_request(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    send_request(20'd519888, 20'd415148, 16'd30000);
    drain();

    // random phases; the idle and stall mix rotates over four patterns, every third phase takes a random calibration
    for (int ph = 0; ph < RandomPhases; ph++) begin
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 76; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 76; end
        default: begin idle_pct = 31; stall_pct = 31; end
      endcase
      if (ph % 3 == 2) begin
        load_calibration({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                         {$urandom, $urandom}, {$urandom, $urandom});
      end else begin
        // nudge the typical calibration so values stay plausible
        jitter = {16'($urandom_range(63)), 16'($urandom_range(63)),
                  16'($urandom_range(63)), 16'($urandom_range(63))};
        load_calibration(TypTemp ^ (jitter & 64'h0000_003F_003F_003F), TypPresA ^ jitter,
                         TypPresB ^ jitter, TypPres9 ^ (jitter & 64'h3F),
                         TypHum ^ (jitter & 64'h0F0F_0F0F_0F0F_0F0F));
      end
      for (k = 0; k < PerPhase; k++) begin
        send_random_request();
        // sender holds off once mid-phase until everything is back
        if (ph == 1 && k == PerPhase / 2) begin
          in_valid_i <= 1'b0;
          while (pending != 0) @(posedge clk_i);
        end
      end
      drain();
    end

    $display("sent %0d readings over %0d calibration settings", requests_sent, settings_used);
    $display("results with invalid pressure: %0d, with saturated pressure: %0d",
             invalid_seen, saturated_seen);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
